/* src/dfe_pkg.sv */
// Shared types, constants and helpers of the delimited field extractor.
// No dependencies; used by every module of the block.
package dfe_pkg;

    localparam int MAX_DELIM   = 4;
    localparam int CHAR_W      = 16;
    localparam int LEN_W       = 3;
    localparam int IDX_W       = $clog2(MAX_DELIM);
    localparam int PAT_W       = MAX_DELIM * CHAR_W;
    localparam int CNT_W       = 16;
    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int REG_IDX_W   = 3;

    localparam logic [KIND_W-1:0] KIND_CONTENT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISCARD  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FINISH   = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_LEFT_PATTERN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_LENGTH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_PATTERN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_LENGTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_ENABLE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FIELD_LIMIT   = 3'd5;

    typedef logic [MAX_DELIM-1:0][CHAR_W-1:0] hist_t;

    typedef struct packed {
        logic [PAT_W-1:0] left_pattern;
        logic [LEN_W-1:0] left_length;
        logic [PAT_W-1:0] right_pattern;
        logic [LEN_W-1:0] right_length;
        logic             limit_enable;
        logic [CNT_W-1:0] field_limit;
    } cfg_t;

    typedef struct packed {
        hist_t            history;
        logic [LEN_W-1:0] fill_count;
        logic             capturing;
        logic [CNT_W-1:0] field_total;
        logic             stopped;
    } scan_state_t;

    // Results caused by one transfer, emitted in field order.
    typedef struct packed {
        logic              content;
        logic              complete;
        logic              discard;
        logic              finish;
        logic [CHAR_W-1:0] ch;
        logic [CNT_W-1:0]  found;
    } res_set_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = (len > LEN_W'(MAX_DELIM)) ? LEN_W'(MAX_DELIM) : len;
        return res;
    endfunction

    // Newest len characters, all since the last match, spell the pattern.
    function automatic logic window_match(input logic [PAT_W-1:0] pat,
                                          input logic [LEN_W-1:0] len,
                                          input hist_t            h,
                                          input logic [LEN_W-1:0] fill);
        logic             ok;
        logic [LEN_W-1:0] idx;
        ok = (len != '0) && (fill >= len);
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            idx = len - LEN_W'(i) - LEN_W'(1);
            if ((LEN_W'(i) < len) && (h[idx[IDX_W-1:0]] != pat[CHAR_W*i +: CHAR_W]))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

/* src/dfe_cfg_regs.sv */
// APB-style register file holding the delimiter and limit settings.
// Depends on dfe_pkg.
module dfe_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dfe_pkg::ADDR_W-1:0] paddr,
    input  logic [dfe_pkg::DATA_W-1:0] pwdata,
    output logic [dfe_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dfe_pkg::cfg_t              cfg
);

    dfe_pkg::cfg_t                    cfg_reg;
    logic [dfe_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[dfe_pkg::ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                dfe_pkg::REG_LEFT_PATTERN:
                    cfg_reg.left_pattern <= pwdata[dfe_pkg::PAT_W-1:0];
                dfe_pkg::REG_LEFT_LENGTH:
                    cfg_reg.left_length <= pwdata[dfe_pkg::LEN_W-1:0];
                dfe_pkg::REG_RIGHT_PATTERN:
                    cfg_reg.right_pattern <= pwdata[dfe_pkg::PAT_W-1:0];
                dfe_pkg::REG_RIGHT_LENGTH:
                    cfg_reg.right_length <= pwdata[dfe_pkg::LEN_W-1:0];
                dfe_pkg::REG_LIMIT_ENABLE:
                    cfg_reg.limit_enable <= pwdata[0];
                dfe_pkg::REG_FIELD_LIMIT:
                    cfg_reg.field_limit <= pwdata[dfe_pkg::CNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            dfe_pkg::REG_LEFT_PATTERN:
                prdata = dfe_pkg::DATA_W'(cfg_reg.left_pattern);
            dfe_pkg::REG_LEFT_LENGTH:
                prdata = dfe_pkg::DATA_W'(cfg_reg.left_length);
            dfe_pkg::REG_RIGHT_PATTERN:
                prdata = dfe_pkg::DATA_W'(cfg_reg.right_pattern);
            dfe_pkg::REG_RIGHT_LENGTH:
                prdata = dfe_pkg::DATA_W'(cfg_reg.right_length);
            dfe_pkg::REG_LIMIT_ENABLE:
                prdata = dfe_pkg::DATA_W'(cfg_reg.limit_enable);
            dfe_pkg::REG_FIELD_LIMIT:
                prdata = dfe_pkg::DATA_W'(cfg_reg.field_limit);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* src/dfe_scan_step.sv */
// Per-character scan logic: delimiter window compares and field bookkeeping.
// Purely combinational; depends on dfe_pkg.
module dfe_scan_step (
    input  dfe_pkg::cfg_t               cfg,
    input  dfe_pkg::scan_state_t        state,
    input  logic [dfe_pkg::CHAR_W-1:0]  text_char,
    input  logic                        text_last,
    output dfe_pkg::scan_state_t        state_next,
    output dfe_pkg::res_set_t           results
);

    logic [dfe_pkg::LEN_W-1:0] llen;
    logic [dfe_pkg::LEN_W-1:0] rlen;
    logic [dfe_pkg::LEN_W-1:0] rlen_m1;
    dfe_pkg::hist_t            pushed_hist;
    logic [dfe_pkg::LEN_W-1:0] pushed_fill;
    logic [dfe_pkg::CNT_W-1:0] total_inc;
    logic                      active;
    logic                      left_hit;
    logic                      right_hit;

    assign llen        = dfe_pkg::clamp_len(cfg.left_length);
    assign rlen        = dfe_pkg::clamp_len(cfg.right_length);
    assign rlen_m1     = rlen - dfe_pkg::LEN_W'(1);
    assign active      = (llen != '0) && (rlen != '0) && !state.stopped;
    assign pushed_hist = {state.history[dfe_pkg::MAX_DELIM-2:0], text_char};
    assign pushed_fill = (state.fill_count < dfe_pkg::LEN_W'(dfe_pkg::MAX_DELIM))
                         ? state.fill_count + dfe_pkg::LEN_W'(1) : state.fill_count;
    assign total_inc   = (state.field_total != '1)
                         ? state.field_total + dfe_pkg::CNT_W'(1) : state.field_total;
    assign left_hit    = dfe_pkg::window_match(cfg.left_pattern, llen, pushed_hist,
                                               pushed_fill);
    assign right_hit   = dfe_pkg::window_match(cfg.right_pattern, rlen, pushed_hist,
                                               pushed_fill);

    always_comb
    begin
        state_next = state;
        results    = '0;
        if (active)
        begin
            if (!state.capturing)
            begin
                if (cfg.limit_enable && (state.field_total >= cfg.field_limit))
                begin
                    state_next.stopped = 1'b1;
                end
                else
                begin
                    state_next.history    = pushed_hist;
                    state_next.fill_count = pushed_fill;
                    if (left_hit)
                    begin
                        state_next.capturing  = 1'b1;
                        state_next.fill_count = '0;
                    end
                end
            end
            else
            begin
                if (state.fill_count >= rlen)
                begin
                    results.content = 1'b1;
                    results.ch      = state.history[rlen_m1[dfe_pkg::IDX_W-1:0]];
                end
                state_next.history    = pushed_hist;
                state_next.fill_count = pushed_fill;
                if (right_hit)
                begin
                    results.complete       = 1'b1;
                    state_next.capturing   = 1'b0;
                    state_next.fill_count  = '0;
                    state_next.field_total = total_inc;
                    if (cfg.limit_enable && (total_inc >= cfg.field_limit))
                    begin
                        state_next.stopped = 1'b1;
                    end
                end
            end
        end
        if (text_last)
        begin
            results.discard = state_next.capturing;
            results.finish  = 1'b1;
            results.found   = state_next.field_total;
            state_next      = '0;
        end
    end

endmodule

/* src/dfe_result_queue.sv */
// Holds the results of one transfer and feeds them out one per cycle while
// result_ready is high, through a registered output stage. Depends on dfe_pkg.
module dfe_result_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  dfe_pkg::res_set_t           results,
    output logic                        load_ready,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [dfe_pkg::KIND_W-1:0]  kind,
    output logic [dfe_pkg::CHAR_W-1:0]  out_char,
    output logic [dfe_pkg::CNT_W-1:0]   fields_found,
    output logic                        run_last
);

    logic [3:0]                 flags_reg;
    logic [3:0]                 flags_next;
    logic [dfe_pkg::CHAR_W-1:0] ch_reg;
    logic [dfe_pkg::CNT_W-1:0]  found_reg;
    logic                       valid_reg;
    logic [dfe_pkg::KIND_W-1:0] kind_reg;
    logic [dfe_pkg::CHAR_W-1:0] char_reg;
    logic [dfe_pkg::CNT_W-1:0]  count_reg;
    logic                       last_reg;
    logic                       out_free;
    logic                       pending;
    logic                       single;
    logic                       move;
    logic [dfe_pkg::KIND_W-1:0] head_kind;
    logic [3:0]                 head_clear;

    // flags: [3] content, [2] complete, [1] discard, [0] finish
    assign pending    = |flags_reg;
    assign single     = $onehot(flags_reg);
    assign out_free   = !valid_reg || result_ready;
    assign move       = pending && out_free;
    assign load_ready = !pending || (move && single);

    always_comb
    begin
        head_kind  = dfe_pkg::KIND_FINISH;
        head_clear = 4'b0001;
        if (flags_reg[3])
        begin
            head_kind  = dfe_pkg::KIND_CONTENT;
            head_clear = 4'b1000;
        end
        else if (flags_reg[2])
        begin
            head_kind  = dfe_pkg::KIND_COMPLETE;
            head_clear = 4'b0100;
        end
        else if (flags_reg[1])
        begin
            head_kind  = dfe_pkg::KIND_DISCARD;
            head_clear = 4'b0010;
        end
        flags_next = flags_reg;
        if (load)
        begin
            flags_next = {results.content, results.complete, results.discard,
                          results.finish};
        end
        else if (move)
        begin
            flags_next = flags_reg & ~head_clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg <= flags_next;
            if (move)
            begin
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ch_reg    <= results.ch;
            found_reg <= results.found;
        end
        if (move)
        begin
            kind_reg  <= head_kind;
            char_reg  <= (head_kind == dfe_pkg::KIND_CONTENT) ? ch_reg : '0;
            count_reg <= (head_kind == dfe_pkg::KIND_FINISH) ? found_reg : '0;
            last_reg  <= single;
        end
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign out_char     = char_reg;
    assign fields_found = count_reg;
    assign run_last     = last_reg;

endmodule

/* src/delimited_field_extractor_unit.sv */
// Top level of the delimited field extractor: register file, scan logic,
// scan state registers and result queue. Depends on dfe_pkg and all dfe_ modules.
//
// Usage:
//   Text enters on text_valid/text_ready, one 16-bit character per transfer,
//   text_last marking the final character. Results leave on
//   result_valid/result_ready as (kind, out_char, fields_found, run_last):
//   content characters, field-complete marks, a discard mark for a field
//   still open at text end, and a finish record carrying the field count.
//   run_last flags the final result caused by one input character.
//   Delimiters and the field limit must be written through the APB port only
//   while the block is idle, which it does not enforce; pready is tied high
//   and reads return register values. Results pass from the queue flags to
//   the output register. Throughput: one character per cycle while each causes
//   at most one result and result_ready is high; else text_ready is low until
//   a character's last result moves, the output register draining one result
//   per cycle while result_ready is high. Content is delayed by right_length
//   characters inside a field. Reset clears the scan state, registers and
//   buffered results. On a receiver stall the output register holds and one
//   further character's results are buffered before text_ready drops.
module delimited_field_extractor_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dfe_pkg::ADDR_W-1:0]  paddr,
    input  logic [dfe_pkg::DATA_W-1:0]  pwdata,
    output logic [dfe_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        text_valid,
    output logic                        text_ready,
    input  logic [dfe_pkg::CHAR_W-1:0]  text_char,
    input  logic                        text_last,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [dfe_pkg::KIND_W-1:0]  kind,
    output logic [dfe_pkg::CHAR_W-1:0]  out_char,
    output logic [dfe_pkg::CNT_W-1:0]   fields_found,
    output logic                        run_last
);

    dfe_pkg::cfg_t        cfg;
    dfe_pkg::scan_state_t state_reg;
    dfe_pkg::scan_state_t state_next;
    dfe_pkg::res_set_t    results;
    logic                 accept;

    assign accept = text_valid && text_ready;

    dfe_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dfe_scan_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .text_char  (text_char),
        .text_last  (text_last),
        .state_next (state_next),
        .results    (results)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    dfe_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .results      (results),
        .load_ready   (text_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .out_char     (out_char),
        .fields_found (fields_found),
        .run_last     (run_last)
    );

endmodule

/* src/dfe_checker.sv */
// Port-level checks of the result channel of delimited_field_extractor_unit.
// Depends on dfe_pkg; bound to the top level below.
module dfe_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [dfe_pkg::KIND_W-1:0]  kind,
    input logic [dfe_pkg::CHAR_W-1:0]  out_char,
    input logic [dfe_pkg::CNT_W-1:0]   fields_found,
    input logic                        run_last
);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(kind)
            && $stable(out_char) && $stable(fields_found) && $stable(run_last))
    else $error("result transfer changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind != dfe_pkg::KIND_CONTENT) |-> out_char == '0)
    else $error("out_char nonzero outside a content transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind != dfe_pkg::KIND_FINISH) |-> fields_found == '0)
    else $error("fields_found nonzero outside a finish transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == dfe_pkg::KIND_FINISH) |-> run_last)
    else $error("finish transfer not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == dfe_pkg::KIND_DISCARD) |-> !run_last)
    else $error("discard transfer marked last");

endmodule

bind delimited_field_extractor_unit dfe_checker u_dfe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .out_char     (out_char),
    .fields_found (fields_found),
    .run_last     (run_last)
);

/* test/tb_delimited_field_extractor_unit.sv */
// Testbench for delimited_field_extractor_unit: directed and random texts checked
// against a behavioral scoreboard. Depends on dfe_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_delimited_field_extractor_unit;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 120;

    localparam logic [dfe_pkg::CHAR_W-1:0] CH_OPEN  = 16'h0028;
    localparam logic [dfe_pkg::CHAR_W-1:0] CH_CLOSE = 16'h0029;

    typedef struct packed {
        logic [dfe_pkg::KIND_W-1:0] kind;
        logic [dfe_pkg::CHAR_W-1:0] ch;
        logic [dfe_pkg::CNT_W-1:0]  found;
        logic                       run_last;
    } extract_rec_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [dfe_pkg::ADDR_W-1:0]    paddr = '0;
    logic [dfe_pkg::DATA_W-1:0]    pwdata = '0;
    logic [dfe_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          text_valid = 1'b0;
    logic                          text_ready;
    logic [dfe_pkg::CHAR_W-1:0]    text_char = '0;
    logic                          text_last = 1'b0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic [dfe_pkg::KIND_W-1:0]    kind;
    logic [dfe_pkg::CHAR_W-1:0]    out_char;
    logic [dfe_pkg::CNT_W-1:0]     fields_found;
    logic                          run_last;

    // shadow configuration and scan state
    dfe_pkg::cfg_t                 shadow;
    logic [dfe_pkg::CHAR_W-1:0]    scan_hist [dfe_pkg::MAX_DELIM];
    int unsigned                   scan_fill;
    bit                            scan_capturing;
    logic [dfe_pkg::CNT_W-1:0]     scan_total;
    bit                            scan_stopped;

    extract_rec_t                  expected_results [$];
    logic [dfe_pkg::CHAR_W-1:0]    alphabet [4];
    int                            error_count = 0;
    int                            cycle_count = 0;
    int                            stall_left = 0;
    int                            random_items = 0;
    bit                            send_steady = 1'b0;
    bit                            recv_steady = 1'b0;

    delimited_field_extractor_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_char    (text_char),
        .text_last    (text_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .out_char     (out_char),
        .fields_found (fields_found),
        .run_last     (run_last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (recv_steady || $urandom_range(0, 99) < 70)
        begin
            result_ready <= 1'b1;
        end
        else
        begin
            result_ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                      : $urandom_range(6, 20);
        end
    end

    always @(posedge clk)
    begin
        extract_rec_t exp_rec;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: kind %0d char %h",
                       kind, out_char);
                error_count++;
            end
            else
            begin
                exp_rec = expected_results.pop_front();
                if (kind !== exp_rec.kind)
                begin
                    $error("kind: expected %0d, actual %0d", exp_rec.kind, kind);
                    error_count++;
                end
                if (out_char !== exp_rec.ch)
                begin
                    $error("out_char: expected %h, actual %h", exp_rec.ch, out_char);
                    error_count++;
                end
                if (fields_found !== exp_rec.found)
                begin
                    $error("fields_found: expected %0d, actual %0d", exp_rec.found,
                           fields_found);
                    error_count++;
                end
                if (run_last !== exp_rec.run_last)
                begin
                    $error("run_last: expected %0d, actual %0d", exp_rec.run_last, run_last);
                    error_count++;
                end
            end
        end
    end

    function automatic int unsigned eff_len(input logic [dfe_pkg::LEN_W-1:0] len);
        return (len > dfe_pkg::MAX_DELIM) ? dfe_pkg::MAX_DELIM : int'(len);
    endfunction

    function automatic bit window_hit(input logic [dfe_pkg::PAT_W-1:0] pat,
                                      input int unsigned len);
        bit hit;
        hit = (len != 0) && (scan_fill >= len);
        for (int i = 0; i < len; i++)
        begin
            if (scan_hist[len - 1 - i] != pat[dfe_pkg::CHAR_W*i +: dfe_pkg::CHAR_W])
                hit = 1'b0;
        end
        return hit;
    endfunction

    task automatic clear_scan();
        for (int i = 0; i < dfe_pkg::MAX_DELIM; i++)
            scan_hist[i] = '0;
        scan_fill = 0;
        scan_capturing = 1'b0;
        scan_total = '0;
        scan_stopped = 1'b0;
    endtask

    task automatic shift_in(input logic [dfe_pkg::CHAR_W-1:0] c);
        for (int i = dfe_pkg::MAX_DELIM - 1; i > 0; i--)
            scan_hist[i] = scan_hist[i - 1];
        scan_hist[0] = c;
        if (scan_fill < dfe_pkg::MAX_DELIM)
            scan_fill++;
    endtask

    task automatic predict_extraction(input logic [dfe_pkg::CHAR_W-1:0] c,
                                      input logic is_last);
        extract_rec_t recs [3];
        int           n;
        int unsigned  llen;
        int unsigned  rlen;
        n = 0;
        llen = eff_len(shadow.left_length);
        rlen = eff_len(shadow.right_length);
        if (llen != 0 && rlen != 0 && !scan_stopped)
        begin
            if (!scan_capturing)
            begin
                if (shadow.limit_enable && scan_total >= shadow.field_limit)
                begin
                    scan_stopped = 1'b1;
                end
                else
                begin
                    shift_in(c);
                    if (window_hit(shadow.left_pattern, llen))
                    begin
                        scan_capturing = 1'b1;
                        scan_fill = 0;
                    end
                end
            end
            else
            begin
                if (scan_fill >= rlen)
                begin
                    recs[n] = '{dfe_pkg::KIND_CONTENT, scan_hist[rlen - 1], '0, 1'b0};
                    n++;
                end
                shift_in(c);
                if (window_hit(shadow.right_pattern, rlen))
                begin
                    recs[n] = '{dfe_pkg::KIND_COMPLETE, '0, '0, 1'b0};
                    n++;
                    scan_capturing = 1'b0;
                    scan_fill = 0;
                    if (scan_total != 16'hFFFF)
                        scan_total++;
                    if (shadow.limit_enable && scan_total >= shadow.field_limit)
                        scan_stopped = 1'b1;
                end
            end
        end
        if (is_last)
        begin
            if (scan_capturing)
            begin
                recs[n] = '{dfe_pkg::KIND_DISCARD, '0, '0, 1'b0};
                n++;
            end
            recs[n] = '{dfe_pkg::KIND_FINISH, '0, scan_total, 1'b0};
            n++;
            clear_scan();
        end
        if (n > 0)
            recs[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results = {expected_results, recs[i]};
    endtask

    function automatic int pick_gap();
        int r;
        if (send_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    task automatic send_char(input logic [dfe_pkg::CHAR_W-1:0] c, input logic is_last);
        int gap;
        text_valid <= 1'b1;
        text_char <= c;
        text_last <= is_last;
        do
            @(posedge clk);
        while (text_ready !== 1'b1);
        predict_extraction(c, is_last);
        gap = pick_gap();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        text_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dfe_pkg::REG_IDX_W-1:0] idx,
                             input logic [dfe_pkg::DATA_W-1:0] val);
        logic [dfe_pkg::DATA_W-1:0] mask;
        logic [dfe_pkg::DATA_W-1:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            dfe_pkg::REG_LEFT_PATTERN:
            begin
                shadow.left_pattern = val;
                mask = '1;
            end
            dfe_pkg::REG_LEFT_LENGTH:
            begin
                shadow.left_length = val[dfe_pkg::LEN_W-1:0];
                mask = 64'h7;
            end
            dfe_pkg::REG_RIGHT_PATTERN:
            begin
                shadow.right_pattern = val;
                mask = '1;
            end
            dfe_pkg::REG_RIGHT_LENGTH:
            begin
                shadow.right_length = val[dfe_pkg::LEN_W-1:0];
                mask = 64'h7;
            end
            dfe_pkg::REG_LIMIT_ENABLE:
            begin
                shadow.limit_enable = val[0];
                mask = 64'h1;
            end
            default:
            begin
                shadow.field_limit = val[dfe_pkg::CNT_W-1:0];
                mask = 64'hFFFF;
            end
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== (val & mask))
        begin
            $error("prdata: expected %h, actual %h", val & mask, rd);
            error_count++;
        end
    endtask

    task automatic configure(input logic [dfe_pkg::PAT_W-1:0] lp,
                             input logic [dfe_pkg::LEN_W-1:0] ll,
                             input logic [dfe_pkg::PAT_W-1:0] rp,
                             input logic [dfe_pkg::LEN_W-1:0] rl,
                             input logic en, input logic [dfe_pkg::CNT_W-1:0] lim);
        write_reg(dfe_pkg::REG_LEFT_PATTERN, lp);
        write_reg(dfe_pkg::REG_LEFT_LENGTH, dfe_pkg::DATA_W'(ll));
        write_reg(dfe_pkg::REG_RIGHT_PATTERN, rp);
        write_reg(dfe_pkg::REG_RIGHT_LENGTH, dfe_pkg::DATA_W'(rl));
        write_reg(dfe_pkg::REG_LIMIT_ENABLE, dfe_pkg::DATA_W'(en));
        write_reg(dfe_pkg::REG_FIELD_LIMIT, dfe_pkg::DATA_W'(lim));
    endtask

    task automatic test_basic_field();
        wait_idle();
        configure(64'(CH_OPEN), 3'd1, 64'({CH_CLOSE, CH_CLOSE}), 3'd2, 1'b0, 16'd0);
        send_char(CH_OPEN, 1'b0);
        send_char(16'hFFFF, 1'b0);
        send_char(16'h0000, 1'b0);
        send_char(CH_CLOSE, 1'b0);
        send_char(CH_CLOSE, 1'b1);
    endtask

    task automatic test_open_field_discard();
        wait_idle();
        send_char(CH_OPEN, 1'b0);
        send_char(16'h0041, 1'b0);
        send_char(16'h0042, 1'b1);
    endtask

    task automatic test_empty_delimiter();
        wait_idle();
        configure(64'(CH_OPEN), 3'd1, 64'(CH_CLOSE), 3'd0, 1'b0, 16'd0);
        send_char(CH_OPEN, 1'b0);
        send_char(CH_CLOSE, 1'b1);
        wait_idle();
        write_reg(dfe_pkg::REG_LEFT_LENGTH, 64'd0);
        write_reg(dfe_pkg::REG_RIGHT_LENGTH, 64'd1);
        send_char(CH_OPEN, 1'b1);
    endtask

    task automatic test_overlong_delimiter();
        wait_idle();
        configure(64'h0044_0043_0042_0041, 3'd7, 64'(CH_CLOSE), 3'd1, 1'b0, 16'd0);
        send_char(16'h0041, 1'b0);
        send_char(16'h0042, 1'b0);
        send_char(16'h0043, 1'b0);
        send_char(16'h0044, 1'b0);
        send_char(16'h0078, 1'b0);
        send_char(CH_CLOSE, 1'b1);
    endtask

    task automatic test_field_limit();
        wait_idle();
        configure(64'(CH_OPEN), 3'd1, 64'(CH_CLOSE), 3'd1, 1'b1, 16'd1);
        send_char(CH_OPEN, 1'b0);
        send_char(16'h0061, 1'b0);
        send_char(CH_CLOSE, 1'b0);
        send_char(CH_OPEN, 1'b0);
        send_char(16'h0062, 1'b0);
        send_char(CH_CLOSE, 1'b1);
        wait_idle();
        write_reg(dfe_pkg::REG_FIELD_LIMIT, 64'd0);
        send_char(CH_OPEN, 1'b0);
        send_char(16'h0061, 1'b0);
        send_char(CH_CLOSE, 1'b1);
    endtask

    // right delimiter shortened while a field is open
    task automatic test_midtext_reconfig();
        wait_idle();
        configure(64'(CH_OPEN), 3'd1, 64'({CH_CLOSE, CH_CLOSE}), 3'd2, 1'b0, 16'd0);
        send_char(CH_OPEN, 1'b0);
        send_char(16'h0061, 1'b0);
        send_char(16'h0062, 1'b0);
        wait_idle();
        write_reg(dfe_pkg::REG_RIGHT_LENGTH, 64'd1);
        send_char(CH_CLOSE, 1'b1);
    endtask

    function automatic logic [dfe_pkg::CHAR_W-1:0] noise_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return shadow.left_pattern[dfe_pkg::CHAR_W*$urandom_range(0, 3)
                                       +: dfe_pkg::CHAR_W];
        if (r < 4)
            return shadow.right_pattern[dfe_pkg::CHAR_W*$urandom_range(0, 3)
                                        +: dfe_pkg::CHAR_W];
        if (r < 7)
            return alphabet[$urandom_range(0, 3)];
        return dfe_pkg::CHAR_W'($urandom);
    endfunction

    function automatic logic [dfe_pkg::LEN_W-1:0] random_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r < 17)
            return dfe_pkg::LEN_W'($urandom_range(1, 4));
        return dfe_pkg::LEN_W'($urandom_range(5, 7));
    endfunction

    task automatic randomize_config(input int phase);
        logic [dfe_pkg::PAT_W-1:0] lp;
        logic [dfe_pkg::PAT_W-1:0] rp;
        logic [dfe_pkg::CNT_W-1:0] lim;
        for (int i = 0; i < 4; i++)
            alphabet[i] = ($urandom_range(0, 1) == 0)
                          ? dfe_pkg::CHAR_W'($urandom_range(0, 3))
                          : dfe_pkg::CHAR_W'($urandom);
        if (phase == 0)
        begin
            configure('1, 3'd4, '1, 3'd4, 1'b1, 16'hFFFF);
        end
        else if (phase == 1)
        begin
            configure('0, 3'd1, '0, 3'd1, 1'b0, 16'h0000);
        end
        else
        begin
            for (int i = 0; i < dfe_pkg::MAX_DELIM; i++)
            begin
                lp[dfe_pkg::CHAR_W*i +: dfe_pkg::CHAR_W] = ($urandom_range(0, 4) != 0)
                    ? alphabet[$urandom_range(0, 3)] : dfe_pkg::CHAR_W'($urandom);
                rp[dfe_pkg::CHAR_W*i +: dfe_pkg::CHAR_W] = ($urandom_range(0, 4) != 0)
                    ? alphabet[$urandom_range(0, 3)] : dfe_pkg::CHAR_W'($urandom);
            end
            lim = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                              : dfe_pkg::CNT_W'($urandom_range(0, 4));
            configure(lp, random_len(), rp, random_len(), $urandom_range(0, 2) == 0, lim);
        end
    endtask

    task automatic send_random_text();
        logic [dfe_pkg::CHAR_W-1:0] chars [$];
        int unsigned                llen;
        int unsigned                rlen;
        int                         nseg;
        llen = eff_len(shadow.left_length);
        rlen = eff_len(shadow.right_length);
        nseg = $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++)
        begin
            repeat ($urandom_range(0, 3)) chars = {chars, noise_char()};
            if ($urandom_range(0, 9) < 8)
            begin
                for (int j = 0; j < llen; j++)
                    chars = {chars,
                             shadow.left_pattern[dfe_pkg::CHAR_W*j +: dfe_pkg::CHAR_W]};
                repeat ($urandom_range(0, 5)) chars = {chars, noise_char()};
                if ($urandom_range(0, 9) < 8)
                begin
                    for (int j = 0; j < rlen; j++)
                        chars = {chars,
                                 shadow.right_pattern[dfe_pkg::CHAR_W*j +: dfe_pkg::CHAR_W]};
                end
                else
                begin
                    for (int j = 0; j < $urandom_range(0, 3) && j < rlen; j++)
                        chars = {chars,
                                 shadow.right_pattern[dfe_pkg::CHAR_W*j +: dfe_pkg::CHAR_W]};
                end
            end
        end
        if (chars.size() == 0)
            chars = {chars, noise_char()};
        for (int k = 0; k < chars.size(); k++)
        begin
            send_char(chars[k], k == chars.size() - 1);
            random_items++;
        end
    endtask

    task automatic test_random_texts();
        int phase;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            randomize_config(phase);
            send_steady = ($urandom_range(0, 3) == 0);
            recv_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 3)) send_random_text();
            phase++;
        end
    endtask

    initial
    begin
        shadow = '0;
        clear_scan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_field();
        test_open_field_discard();
        test_empty_delimiter();
        test_overlong_delimiter();
        test_field_limit();
        test_midtext_reconfig();
        test_random_texts();
        wait_idle();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
